FILE: rtl/kpd_pkg.sv
// ----------------------------------------------------------------------------
// Keypad scanner package
// Shared types, state codes and lookup tables for the keypad scanner.
// ----------------------------------------------------------------------------
package kpd_pkg;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_PRESS   = 2'd1;
    localparam logic [1:0] ST_PROCESS = 2'd2;
    localparam logic [1:0] ST_RELEASE = 2'd3;

    localparam logic [4:0]  CODE_BLANK  = 5'd16;
    localparam logic [15:0] PULSE_MAX   = 16'hFFFF;
    localparam logic [15:0] LIMIT_RESET = 16'd100;
    localparam int          MSG_LEN     = 4;
    localparam logic [2:0]  BURST_LAST  = 3'd4;

    localparam logic [7:0] MSG_RESET_0 = 8'h42;
    localparam logic [7:0] MSG_RESET_1 = 8'h45;
    localparam logic [7:0] MSG_RESET_2 = 8'h45;
    localparam logic [7:0] MSG_RESET_3 = 8'h46;

    typedef struct packed {
        logic       load;
        logic       burst;
        logic [1:0] row;
        logic [7:0] seg;
    } kpd_res_t;

    function automatic logic [7:0] seg_of(input logic [4:0] code);
        logic [7:0] s;
        case (code)
            5'd0:    s = 8'hC0;
            5'd1:    s = 8'hF9;
            5'd2:    s = 8'hA4;
            5'd3:    s = 8'hB0;
            5'd4:    s = 8'h99;
            5'd5:    s = 8'h92;
            5'd6:    s = 8'h82;
            5'd7:    s = 8'hF8;
            5'd8:    s = 8'h80;
            5'd9:    s = 8'h90;
            5'd10:   s = 8'h88;
            5'd11:   s = 8'h83;
            5'd12:   s = 8'hC6;
            5'd13:   s = 8'hA1;
            5'd14:   s = 8'h86;
            5'd15:   s = 8'h8E;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] key_of(input logic [1:0] row, input logic [3:0] cols);
        logic [4:0] k;
        k = CODE_BLANK;
        case (cols)
            4'd1:
            begin
                case (row)
                    2'd0:    k = 5'd13;
                    2'd1:    k = 5'd10;
                    2'd2:    k = 5'd11;
                    default: k = 5'd12;
                endcase
            end
            4'd2:
            begin
                case (row)
                    2'd0:    k = 5'd15;
                    2'd1:    k = 5'd3;
                    2'd2:    k = 5'd6;
                    default: k = 5'd9;
                endcase
            end
            4'd4:
            begin
                case (row)
                    2'd0:    k = 5'd0;
                    2'd1:    k = 5'd2;
                    2'd2:    k = 5'd5;
                    default: k = 5'd8;
                endcase
            end
            4'd8:
            begin
                case (row)
                    2'd0:    k = 5'd14;
                    2'd1:    k = 5'd1;
                    2'd2:    k = 5'd4;
                    default: k = 5'd7;
                endcase
            end
            default: k = CODE_BLANK;
        endcase
        return k;
    endfunction

    // Hex ASCII to digit code; blank when the byte is not a hex character.
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [4:0] v;
        v = CODE_BLANK;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 5'(c - 8'h30);
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 5'(c - 8'h37);
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

FILE: rtl/kpd_core.sv
// ----------------------------------------------------------------------------
// Keypad scanner core
// Scan index, debounce state machine, digit store and message store.
// ----------------------------------------------------------------------------
module kpd_core #(
    parameter int DIGITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              op,
    input  logic [3:0]        columns,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    output kpd_pkg::kpd_res_t res,
    output logic [3:0][7:0]   msg
);
    import kpd_pkg::*;

    localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(DIGITS - 1);

    logic [15:0]            limit_reg;
    logic [1:0]             state_reg,   state_next;
    logic [IW-1:0]          scan_reg,    scan_next;
    logic [3:0]             hcols_reg,   hcols_next;
    logic [IW-1:0]          hrow_reg,    hrow_next;
    logic [15:0]            pulse_reg,   pulse_next;
    logic [DIGITS-1:0][4:0] digit_reg,   digit_next;
    logic [IW-1:0]          wr_reg,      wr_next;
    logic [3:0][7:0]        msg_reg,     msg_next;
    logic [IW-1:0]          rcv_reg,     rcv_next;

    logic [IW-1:0] k;
    logic [4:0]    rx_code;
    logic [4:0]    key_code;
    logic          row_hit;

    function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] i);
        return (i == IDX_LAST) ? '0 : IW'(i + 1'b1);
    endfunction

    function automatic logic [1:0] low2(input logic [IW-1:0] i);
        logic [IW+1:0] e;
        e = (IW + 2)'(i);
        return e[1:0];
    endfunction

    assign k        = inc_idx(scan_reg);
    assign rx_code  = hex_of(rx_byte);
    assign key_code = key_of(low2(hrow_reg), hcols_reg);
    assign row_hit  = (k == hrow_reg);
    assign msg      = msg_reg;

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        hcols_next = hcols_reg;
        hrow_next  = hrow_reg;
        pulse_next = pulse_reg;
        digit_next = digit_reg;
        wr_next    = wr_reg;
        msg_next   = msg_reg;
        rcv_next   = rcv_reg;
        res.load   = fire && !op;
        res.burst  = 1'b0;
        res.row    = low2(scan_reg);
        res.seg    = seg_of(digit_reg[scan_reg]);

        if (fire && op)
        begin
            if (rx_code != CODE_BLANK)
            begin
                digit_next[rcv_reg] = rx_code;
            end
            rcv_next = inc_idx(rcv_reg);
        end
        else if (fire)
        begin
            scan_next = k;
            case (state_reg)
                ST_IDLE:
                begin
                    if (columns != 4'd0)
                    begin
                        hcols_next = columns;
                        hrow_next  = k;
                        state_next = ST_PRESS;
                        pulse_next = '0;
                    end
                end
                ST_PRESS:
                begin
                    if (row_hit && columns == hcols_reg && pulse_reg != PULSE_MAX)
                    begin
                        pulse_next = pulse_reg + 16'd1;
                    end
                    if (row_hit && columns != hcols_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    if (pulse_next > limit_reg)
                    begin
                        state_next = ST_PROCESS;
                    end
                end
                ST_PROCESS:
                begin
                    if (hcols_reg == 4'd1 && hrow_reg == '0)
                    begin
                        res.burst = 1'b1;
                        wr_next   = '0;
                    end
                    else
                    begin
                        digit_next[wr_reg] = key_code;
                        if (key_code <= 5'd9)
                        begin
                            msg_next[low2(wr_reg)] = 8'(key_code) + 8'h30;
                        end
                        else if (key_code <= 5'd15)
                        begin
                            msg_next[low2(wr_reg)] = 8'(key_code) + 8'h37;
                        end
                        wr_next = inc_idx(wr_reg);
                    end
                    pulse_next = '0;
                    state_next = ST_RELEASE;
                end
                default:
                begin
                    if (row_hit && columns == 4'd0 && pulse_reg != PULSE_MAX)
                    begin
                        pulse_next = pulse_reg + 16'd1;
                    end
                    if (row_hit && columns != 4'd0)
                    begin
                        pulse_next = '0;
                    end
                    if (pulse_next > limit_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
            hcols_reg <= '0;
            hrow_reg  <= '0;
            pulse_reg <= '0;
            digit_reg <= '0;
            wr_reg    <= '0;
            msg_reg   <= {MSG_RESET_3, MSG_RESET_2, MSG_RESET_1, MSG_RESET_0};
            rcv_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            state_reg <= state_next;
            scan_reg  <= scan_next;
            hcols_reg <= hcols_next;
            hrow_reg  <= hrow_next;
            pulse_reg <= pulse_next;
            digit_reg <= digit_next;
            wr_reg    <= wr_next;
            msg_reg   <= msg_next;
            rcv_reg   <= rcv_next;
        end
    end

endmodule

FILE: rtl/kpd_out.sv
// ----------------------------------------------------------------------------
// Keypad scanner result stage
// Holds the digit drive result and plays out the message burst.
// ----------------------------------------------------------------------------
module kpd_out (
    input  logic              clk,
    input  logic              rst_n,
    input  kpd_pkg::kpd_res_t res,
    input  logic [3:0][7:0]   msg,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              kind,
    output logic [1:0]        row_select,
    output logic [7:0]        segments,
    output logic [7:0]        tx_char,
    output logic              last,
    output logic              free
);
    import kpd_pkg::*;

    logic       valid_reg;
    logic [2:0] beat_reg;
    logic       burst_reg;
    logic [1:0] row_reg;
    logic [7:0] seg_reg;
    logic [1:0] msg_idx;

    assign msg_idx    = 2'(beat_reg - 3'd1);
    assign out_valid  = valid_reg;
    assign kind       = (beat_reg != 3'd0);
    assign row_select = kind ? 2'd0 : row_reg;
    assign segments   = kind ? 8'd0 : seg_reg;
    assign tx_char    = kind ? msg[msg_idx] : 8'd0;
    assign last       = burst_reg ? (beat_reg == BURST_LAST) : 1'b1;
    assign free       = !valid_reg || (out_ready && last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
            burst_reg <= 1'b0;
        end
        else if (res.load)
        begin
            valid_reg <= 1'b1;
            beat_reg  <= '0;
            burst_reg <= res.burst;
        end
        else if (valid_reg && out_ready)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                beat_reg <= beat_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            row_reg <= res.row;
            seg_reg <= res.seg;
        end
    end

    a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last) |-> !free)
        else $error("input taken while a burst is still pending");

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        beat_reg <= BURST_LAST)
        else $error("burst beat counter out of range");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && !last) |=> (valid_reg && kind))
        else $error("burst stopped before its final beat");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !burst_reg) |-> (last && !kind))
        else $error("single digit result not marked final");

endmodule

FILE: rtl/keypad_scan_debounce_display.sv
// ----------------------------------------------------------------------------
// Keypad scanner with debounce and display
// Scans a 4x4 keypad, debounces keys, drives a seven-segment display and
// sends a four-character message and takes hex digits over a byte channel.
// ----------------------------------------------------------------------------
//  Channel  Signals                                   Direction
//  in       in_valid, in_ready, op, columns, rx_byte  into block
//  out      out_valid, out_ready, kind, row_select,   out of block
//           segments, tx_char, last
//  cfg      cfg_we, cfg_wdata                         into block
//
//  A scan tick gives one digit beat; a confirmed D key adds four message beats.
//  A received byte gives no beat. An item is taken every cycle while the result
//  register is empty or its final beat leaves in that cycle; a five-beat burst
//  holds the input until its last beat goes. The result register sets the rate.
//  Reset returns the limit to 100, the message to BEEF and the digits to zero.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_display #(
    parameter int DIGITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [3:0]  columns,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [1:0]  row_select,
    output logic [7:0]  segments,
    output logic [7:0]  tx_char,
    output logic        last,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import kpd_pkg::*;

    kpd_res_t        res;
    logic [3:0][7:0] msg;
    logic            free;
    logic            fire;

    assign in_ready = free;
    assign fire     = in_valid && free;

    kpd_core #(
        .DIGITS (DIGITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .op        (op),
        .columns   (columns),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res       (res),
        .msg       (msg)
    );

    kpd_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .msg        (msg),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .kind       (kind),
        .row_select (row_select),
        .segments   (segments),
        .tx_char    (tx_char),
        .last       (last),
        .free       (free)
    );

endmodule
